// File: hw/rtl/signed_decimal_display_line_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the signed decimal display line core.
// Each macro takes a label, a clock, an active-low reset, an antecedent,
// a consequent and a message string.
// ---------------------------------------------------------------------------
`ifndef SIGNED_DECIMAL_DISPLAY_LINE_CORE_MACROS_SVH
`define SIGNED_DECIMAL_DISPLAY_LINE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define SDDL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define SDDL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SDDL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define SDDL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: hw/rtl/sddl_pkg.sv
// ---------------------------------------------------------------------------
// sddl_pkg
// Types and constants shared by the display line controller and datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sddl_pkg;

  localparam int VALUE_W = 16;
  localparam int POS_W   = 3;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 8;
  localparam int REM_W   = 14;
  localparam int DIG_W   = 4;
  localparam int IDX_W   = 2;

  localparam logic signed [VALUE_W-1:0] MAX_SHOWN = 16'sd9999;
  localparam logic signed [VALUE_W-1:0] MIN_SHOWN = -16'sd999;
  localparam logic [REM_W-1:0] REM_MAX     = 14'd9999;
  localparam logic [REM_W-1:0] REM_NEG_MAX = 14'd999;

  localparam logic [REM_W-1:0] STEP_THOU = 14'd1000;
  localparam logic [REM_W-1:0] STEP_HUND = 14'd100;
  localparam logic [REM_W-1:0] STEP_TENS = 14'd10;

  localparam logic [DIG_W-1:0]  DASH_CODE  = 4'd10;
  localparam logic [ADDR_W-1:0] LINE0_BASE = 4'd1;
  localparam logic [ADDR_W-1:0] LINE1_BASE = 4'd5;
  localparam logic [IDX_W-1:0]  LAST_IDX   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_THOU,
    ST_HUND,
    ST_TENS,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_THOU,
    PH_HUND,
    PH_TENS
  } phase_t;

  typedef struct packed {
    logic             load;
    logic             sub_en;
    phase_t           phase;
    logic             out_load;
    logic [IDX_W-1:0] out_idx;
  } cmd_t;

  typedef struct packed {
    logic fits;
    logic neg;
  } status_t;

endpackage

`default_nettype wire

// File: hw/rtl/sddl_in_if.sv
// ---------------------------------------------------------------------------
// sddl_in_if
// Request channel carrying the value, decimal point position and line select.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sddl_in_if;
  import sddl_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  value;
  logic        [POS_W-1:0]    decimal_position;
  logic                       display_line;

  modport source (output valid, output value, output decimal_position,
                  output display_line, input ready);
  modport sink   (input valid, input value, input decimal_position,
                  input display_line, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sddl_out_if.sv
// ---------------------------------------------------------------------------
// sddl_out_if
// Result channel carrying the display driver register writes, four per request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sddl_out_if;
  import sddl_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] register_address;
  logic [DATA_W-1:0] data_byte;
  logic              last_of_run;

  modport source (output valid, output register_address, output data_byte,
                  output last_of_run, input ready);
  modport sink   (input valid, input register_address, input data_byte,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sddl_ctrl.sv
// ---------------------------------------------------------------------------
// sddl_ctrl
// Sequencer for capture, digit extraction and the four register writes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sddl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire sddl_pkg::status_t status,
  output sddl_pkg::cmd_t         cmd
);
  import sddl_pkg::*;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    cmd          = '0;
    cmd.phase    = PH_THOU;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_THOU;
        end
      end
      ST_THOU: begin
        cmd.phase = PH_THOU;
        // The top digit of a negative value is already the dash.
        if (status.fits && !status.neg) begin
          cmd.sub_en = 1'b1;
        end else begin
          state_nxt = ST_HUND;
        end
      end
      ST_HUND: begin
        cmd.phase = PH_HUND;
        if (status.fits) begin
          cmd.sub_en = 1'b1;
        end else begin
          state_nxt = ST_TENS;
        end
      end
      ST_TENS: begin
        cmd.phase = PH_TENS;
        if (status.fits) begin
          cmd.sub_en = 1'b1;
        end else begin
          cmd.out_load = 1'b1;
          cmd.out_idx  = '0;
          idx_nxt      = '0;
          state_nxt    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.out_load = 1'b1;
            cmd.out_idx  = idx_r + 1'b1;
            idx_nxt      = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/sddl_dp.sv
// ---------------------------------------------------------------------------
// sddl_dp
// Clamp, shared subtract-and-count unit, digit registers and output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sddl_dp (
  input  wire logic                                  clk,
  input  wire sddl_pkg::cmd_t                        cmd,
  output sddl_pkg::status_t                          status,
  input  wire logic signed [sddl_pkg::VALUE_W-1:0]   in_value,
  input  wire logic        [sddl_pkg::POS_W-1:0]     in_decimal_position,
  input  wire logic                                  in_display_line,
  output logic             [sddl_pkg::ADDR_W-1:0]    out_register_address,
  output logic             [sddl_pkg::DATA_W-1:0]    out_data_byte,
  output logic                                       out_last_of_run
);
  import sddl_pkg::*;

  logic [REM_W-1:0]  rem_r;
  logic [DIG_W-1:0]  dig3_r, dig2_r, dig1_r;
  logic              neg_r;
  logic [POS_W-1:0]  pos_r;
  logic              line_r;
  logic [ADDR_W-1:0] addr_r;
  logic [DATA_W-1:0] data_r;
  logic              last_r;

  logic [REM_W-1:0]   mag;
  logic [REM_W-1:0]   neg_value;
  logic [REM_W-1:0]   step;
  logic [DIG_W-1:0]   sel_dig;
  logic               point;
  logic [ADDR_W-1:0]  base;

  // Clamp to the showable range and take the magnitude.
  always_comb begin
    neg_value = '0 - in_value[REM_W-1:0];
    if (in_value > MAX_SHOWN) begin
      mag = REM_MAX;
    end else if (in_value < MIN_SHOWN) begin
      mag = REM_NEG_MAX;
    end else if (in_value[VALUE_W-1]) begin
      mag = neg_value;
    end else begin
      mag = in_value[REM_W-1:0];
    end
  end

  always_comb begin
    case (cmd.phase)
      PH_THOU: step = STEP_THOU;
      PH_HUND: step = STEP_HUND;
      PH_TENS: step = STEP_TENS;
      default: step = STEP_TENS;
    endcase
  end

  assign status.fits = (rem_r >= step);
  assign status.neg  = neg_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r  <= mag;
      neg_r  <= in_value[VALUE_W-1];
      dig3_r <= in_value[VALUE_W-1] ? DASH_CODE : '0;
      dig2_r <= '0;
      dig1_r <= '0;
      pos_r  <= in_decimal_position;
      line_r <= in_display_line;
    end else if (cmd.sub_en) begin
      rem_r <= rem_r - step;
      case (cmd.phase)
        PH_THOU: dig3_r <= dig3_r + 1'b1;
        PH_HUND: dig2_r <= dig2_r + 1'b1;
        PH_TENS: dig1_r <= dig1_r + 1'b1;
        default: dig1_r <= dig1_r;
      endcase
    end
  end

  // Result for one digit index; the ones digit is what the tens pass left.
  always_comb begin
    case (cmd.out_idx)
      2'd0:    sel_dig = rem_r[DIG_W-1:0];
      2'd1:    sel_dig = dig1_r;
      2'd2:    sel_dig = dig2_r;
      default: sel_dig = dig3_r;
    endcase
    point = !pos_r[POS_W-1] && (pos_r[IDX_W-1:0] == cmd.out_idx);
    base  = line_r ? LINE1_BASE : LINE0_BASE;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      addr_r <= base + {{(ADDR_W-IDX_W){1'b0}}, cmd.out_idx};
      data_r <= {point, {(DATA_W-DIG_W-1){1'b0}}, sel_dig};
      last_r <= (cmd.out_idx == LAST_IDX);
    end
  end

  assign out_register_address = addr_r;
  assign out_data_byte        = data_r;
  assign out_last_of_run      = last_r;

endmodule

`default_nettype wire

// File: hw/rtl/signed_decimal_display_line_core.sv
// ---------------------------------------------------------------------------
// signed_decimal_display_line_core
// Signed value to four display driver digit register writes.
// ---------------------------------------------------------------------------
//
//   Channel | Dir | Payload                                      | Per request
//   in_ch   | in  | value, decimal_position, display_line        | 1
//   out_ch  | out | register_address, data_byte, last_of_run     | 4
//
// After a request is taken, the single shared subtract-and-count unit
// performs one subtraction of 1000, 100 or 10 per cycle plus one check
// per decade, followed by the four writes, which proceed while out_ch is
// ready. The sequencer then returns to idle before taking a new request.
// Reset is synchronous and active low and returns the sequencer to idle.
// Stalls on out_ch hold the current write; in_ch takes a new request in the
// cycle after the last write of the previous one has been taken.
`timescale 1ns / 1ps
`default_nettype none
`include "signed_decimal_display_line_core_macros.svh"

module signed_decimal_display_line_core (
  input wire logic   clk,
  input wire logic   rst_n,
  sddl_in_if.sink    in_ch,
  sddl_out_if.source out_ch
);
  import sddl_pkg::*;

  // Command and status between the sequencer and the datapath.
  cmd_t    cmd;
  status_t status;

  // The sequencer decides when a request is taken, when the shared
  // subtractor runs for each decade and when each write is loaded.
  sddl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath clamps the value, counts the digits and holds the write
  // presented on out_ch in its own output register.
  sddl_dp u_dp (
    .clk                  (clk),
    .cmd                  (cmd),
    .status               (status),
    .in_value             (in_ch.value),
    .in_decimal_position  (in_ch.decimal_position),
    .in_display_line      (in_ch.display_line),
    .out_register_address (out_ch.register_address),
    .out_data_byte        (out_ch.data_byte),
    .out_last_of_run      (out_ch.last_of_run)
  );

  // The block never takes a request while a write is pending.
  `SDDL_ASSERT_NOW(a_busy_excl, clk, rst_n, out_ch.valid, !in_ch.ready, "ready while writing")

  // After a request is taken, no other one is taken in the next cycle.
  `SDDL_ASSERT_NEXT(a_one_req, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready, "double take")

  // Taking the last write of a run returns the block to idle.
  `SDDL_ASSERT_NEXT(a_last_idle, clk, rst_n, out_ch.valid && out_ch.ready && out_ch.last_of_run, in_ch.ready && !out_ch.valid, "no idle after last write")

  // A digit code never exceeds the dash and only bit 7 may be set above it.
  `SDDL_ASSERT_NOW(a_code_ok, clk, rst_n, out_ch.valid, out_ch.data_byte[6:4] == 3'd0 && out_ch.data_byte[3:0] <= 4'd10, "bad digit code")

endmodule

`default_nettype wire

// File: sim/tb_signed_decimal_display_line_core.sv
// ---------------------------------------------------------------------------
// tb_signed_decimal_display_line_core
// Checks the signed value to digit register write conversion. A table of
// directed requests runs first (range ends, clamping, dash and decimal point
// placement), then random requests. Every accepted request queues four
// expected register writes that are matched in order against the result
// channel, while both channels idle and stall at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_signed_decimal_display_line_core;
  import sddl_pkg::*;

  localparam logic [DATA_W-1:0] POINT_BIT = 8'h80;
  localparam int DIRECTED_COUNT = 25;
  localparam int RANDOM_COUNT = 125;
  // The drain wait is longer than the longest request.
  localparam int DRAIN_CYCLES = 40;
  // The receiver stops taking writes for this long once, mid-run.
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AT = 100;

  // One directed request. Digit codes are packed top digit first; they are
  // only used when the row carries typed-in results.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   decimal_position;
    logic               display_line;
    logic               typed;
    logic [31:0]        digit_codes;
  } display_case_t;

  // One register write as it should leave the block.
  typedef struct packed {
    logic [ADDR_W-1:0] register_address;
    logic [DATA_W-1:0] data_byte;
    logic              last_of_run;
  } register_write_t;

  localparam display_case_t DIRECTED [DIRECTED_COUNT] = '{
    // Values read straight off: zero, the range ends, clamping on both sides,
    // the dash with and without a decimal point, and all value bits toggled.
    '{16'd0,     3'd7, 1'b0, 1'b1, 32'h00_00_00_00},
    '{16'd9999,  3'd4, 1'b1, 1'b1, 32'h09_09_09_09},
    '{16'h7FFF,  3'd5, 1'b0, 1'b1, 32'h09_09_09_09},
    '{16'd10000, 3'd1, 1'b1, 1'b1, 32'h09_09_89_09},
    '{16'h8000,  3'd6, 1'b1, 1'b1, 32'h0A_09_09_09},
    '{-16'sd999, 3'd3, 1'b0, 1'b1, 32'h8A_09_09_09},
    '{-16'sd1000, 3'd0, 1'b1, 1'b1, 32'h0A_09_09_89},
    '{-16'sd1,   3'd2, 1'b0, 1'b1, 32'h0A_80_00_01},
    '{16'd1,     3'd0, 1'b1, 1'b1, 32'h00_00_00_81},
    '{16'h5555,  3'd3, 1'b0, 1'b1, 32'h89_09_09_09},
    '{16'hAAAA,  3'd2, 1'b1, 1'b1, 32'h0A_89_09_09},
    // Digit boundaries and mixed signs go through the predictor.
    '{16'd1234,  3'd2, 1'b1, 1'b0, 32'h0},
    '{16'd1000,  3'd0, 1'b0, 1'b0, 32'h0},
    '{16'd999,   3'd1, 1'b1, 1'b0, 32'h0},
    '{16'd100,   3'd3, 1'b0, 1'b0, 32'h0},
    '{16'd99,    3'd4, 1'b1, 1'b0, 32'h0},
    '{16'd10,    3'd2, 1'b0, 1'b0, 32'h0},
    '{16'd9,     3'd1, 1'b1, 1'b0, 32'h0},
    '{-16'sd10,  3'd0, 1'b0, 1'b0, 32'h0},
    '{-16'sd100, 3'd3, 1'b1, 1'b0, 32'h0},
    '{-16'sd500, 3'd1, 1'b0, 1'b0, 32'h0},
    '{16'd9998,  3'd3, 1'b1, 1'b0, 32'h0},
    '{-16'sd998, 3'd2, 1'b0, 1'b0, 32'h0},
    '{16'd5000,  3'd7, 1'b1, 1'b0, 32'h0},
    '{-16'sd7,   3'd5, 1'b0, 1'b0, 32'h0}
  };

  logic clk;
  logic rst_n;

  sddl_in_if  in_ch ();
  sddl_out_if out_ch ();

  signed_decimal_display_line_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Register writes owed by the block, oldest first.
  register_write_t pending_writes [$];
  int unsigned     fail_count;
  int unsigned     writes_taken;
  // While set, neither side inserts idle cycles.
  bit              steady_flow;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Converts a value to its four digit codes, top digit in the high byte.
  // The value is clamped first; a negative value shows a dash on top and its
  // magnitude below. The chosen digit, if any, carries the decimal point.
  function automatic logic [31:0] decimal_digit_codes(
    input logic signed [VALUE_W-1:0] value,
    input logic [POS_W-1:0]          point_at
  );
    int shown;
    int mag;
    logic [DATA_W-1:0] code [4];
    shown = value;
    if (shown > MAX_SHOWN) shown = MAX_SHOWN;
    if (shown < MIN_SHOWN) shown = MIN_SHOWN;
    mag = (shown < 0) ? -shown : shown;
    code[3] = (shown < 0) ? {4'd0, DASH_CODE} : DATA_W'(mag / 1000);
    mag = mag % 1000;
    code[2] = DATA_W'(mag / 100);
    mag = mag % 100;
    code[1] = DATA_W'(mag / 10);
    code[0] = DATA_W'(mag % 10);
    if (point_at < 4) code[point_at[IDX_W-1:0]] = code[point_at[IDX_W-1:0]] | POINT_BIT;
    return {code[3], code[2], code[1], code[0]};
  endfunction

  // Offers one request after a random gap and waits until the block takes
  // it. Valid is only lowered when a gap follows, so back-to-back requests
  // keep it high without a second assignment in the same step. Once the
  // request is taken its four writes, ones digit first, join the queue.
  task automatic send_request(
    input logic [VALUE_W-1:0] value,
    input logic [POS_W-1:0]   decimal_position,
    input logic               display_line,
    input logic               typed,
    input logic [31:0]        typed_codes
  );
    int unsigned       gap;
    logic [31:0]       codes;
    logic [ADDR_W-1:0] base;
    register_write_t   wr;
    gap = steady_flow ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.value            <= value;
    in_ch.decimal_position <= decimal_position;
    in_ch.display_line     <= display_line;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    codes = typed ? typed_codes : decimal_digit_codes(value, decimal_position);
    base  = display_line ? LINE1_BASE : LINE0_BASE;
    for (int k = 0; k < 4; k++) begin
      wr.register_address = base + ADDR_W'(k);
      wr.data_byte        = codes[8*k +: 8];
      wr.last_of_run      = (k == int'(LAST_IDX));
      pending_writes.push_back(wr);
    end
  endtask

  // Stimulus: reset, the directed table, then random requests, then drain.
  initial begin : stimulus
    int unsigned        idx;
    logic [VALUE_W-1:0] value;
    steady_flow             = 1'b0;
    fail_count              = 0;
    rst_n                  <= 1'b0;
    in_ch.valid            <= 1'b0;
    in_ch.value            <= '0;
    in_ch.decimal_position <= '0;
    in_ch.display_line     <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (idx = 0; idx < DIRECTED_COUNT; idx++) begin
      send_request(DIRECTED[idx].value, DIRECTED[idx].decimal_position,
                   DIRECTED[idx].display_line, DIRECTED[idx].typed,
                   DIRECTED[idx].digit_codes);
    end

    for (idx = 0; idx < RANDOM_COUNT; idx++) begin
      // A window of random requests runs without any idle cycles on either
      // side, so the block also sees requests and writes back to back.
      steady_flow = (idx >= 40 && idx < 70);
      // Mostly values inside the shown range, some anywhere in 16 bits, and
      // some hugging the clamp thresholds at both ends.
      case ($urandom_range(0, 9))
        6, 7:    value = VALUE_W'($urandom_range(0, 65535));
        8:       value = VALUE_W'(9990 + int'($urandom_range(0, 20)));
        9:       value = VALUE_W'(-1010 + int'($urandom_range(0, 20)));
        default: value = VALUE_W'(int'($urandom_range(0, 10998)) - 999);
      endcase
      send_request(value, POS_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                   1'b0, 32'h0);
    end
    steady_flow = 1'b0;
    in_ch.valid <= 1'b0;

    while (pending_writes.size() != 0) @(posedge clk);
    // Any stray write after the last expected one is still caught here.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Result side: takes writes after a random stall and checks each one
  // against the oldest expected write. Once, it refuses writes for a long
  // stretch so that the block backs up and stops taking requests.
  initial begin : result_sink
    int unsigned     gap;
    register_write_t want;
    writes_taken  = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      gap = steady_flow ? 0 : $urandom_range(0, 7);
      if (writes_taken == HOLD_OFF_AT) gap = HOLD_OFF_CYCLES;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
      writes_taken++;
      if (pending_writes.size() == 0) begin
        $error("unexpected write: register_address %0d, data_byte 0x%02h, last_of_run %0b",
               out_ch.register_address, out_ch.data_byte, out_ch.last_of_run);
        fail_count++;
      end else begin
        want = pending_writes.pop_front();
        if (out_ch.register_address !== want.register_address) begin
          $error("register_address: expected %0d, actual %0d",
                 want.register_address, out_ch.register_address);
          fail_count++;
        end
        if (out_ch.data_byte !== want.data_byte) begin
          $error("data_byte: expected 0x%02h, actual 0x%02h",
                 want.data_byte, out_ch.data_byte);
          fail_count++;
        end
        if (out_ch.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0b, actual %0b",
                 want.last_of_run, out_ch.last_of_run);
          fail_count++;
        end
      end
    end
  end

  // Watchdog. Ends the run as failed if it is still going long after a correct
  // run would have finished, even with every gap and stall at its longest.
  initial begin : watchdog
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: signed_decimal_display_line_core.f
+incdir+hw/rtl
hw/rtl/sddl_pkg.sv
hw/rtl/sddl_in_if.sv
hw/rtl/sddl_out_if.sv
hw/rtl/sddl_ctrl.sv
hw/rtl/sddl_dp.sv
hw/rtl/signed_decimal_display_line_core.sv
sim/tb_signed_decimal_display_line_core.sv
